/* hw/rtl/dbd_pkg.sv */
`timescale 1ns / 1ps
package dbd_pkg;
	localparam int NUM_CLASSES_DEF = 80;
	localparam int MAX_PRIORS_DEF = 32768;
	localparam int CLASS_W = 7;
	localparam int PRIOR_W = 15;
	localparam int DIM_W = 13;

	localparam logic [1:0] REG_THRESHOLD = 2'd0;
	localparam logic [1:0] REG_WIDTH = 2'd1;
	localparam logic [1:0] REG_HEIGHT = 2'd2;

	localparam logic [31:0] RECIP10 = 32'hCCCC_CCCD;
	localparam logic [31:0] LOG2E_X_02 = 32'd18910;

	localparam logic [17:0] POW2_TAB [17] = '{
		18'd65536, 18'd68438, 18'd71468, 18'd74632, 18'd77936, 18'd81386,
		18'd84990, 18'd88752, 18'd92682, 18'd96785, 18'd101070, 18'd105545,
		18'd110218, 18'd115098, 18'd120194, 18'd125515, 18'd131072
	};

	typedef struct packed {
		logic signed [15:0] dx;
		logic signed [15:0] dy;
		logic signed [15:0] dw;
		logic signed [15:0] dh;
		logic [15:0] acx;
		logic [15:0] acy;
		logic [15:0] aw;
		logic [15:0] ah;
		logic [CLASS_W-1:0] cls;
		logic [15:0] score;
		logic [PRIOR_W-1:0] prior;
	} dbd_req_t;
endpackage

/* hw/rtl/dbd_decode.sv */
`timescale 1ns / 1ps
module dbd_decode (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  dbd_pkg::dbd_req_t req,
	input  logic [dbd_pkg::DIM_W-1:0] image_width,
	input  logic [dbd_pkg::DIM_W-1:0] image_height,
	output logic idle,
	output logic out_valid,
	input  logic out_ready,
	output logic [dbd_pkg::CLASS_W-1:0] class_id,
	output logic [15:0] confidence,
	output logic [11:0] box_x,
	output logic [11:0] box_y,
	output logic [12:0] box_w,
	output logic [12:0] box_h,
	output logic [dbd_pkg::PRIOR_W-1:0] prior_index
);
	import dbd_pkg::*;

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_MUL1 = 4'd1;
	localparam logic [3:0] ST_MUL2 = 4'd2;
	localparam logic [3:0] ST_MUL3 = 4'd3;
	localparam logic [3:0] ST_EXP = 4'd4;
	localparam logic [3:0] ST_MUL5 = 4'd5;
	localparam logic [3:0] ST_MANT = 4'd6;
	localparam logic [3:0] ST_MUL7 = 4'd7;
	localparam logic [3:0] ST_SIZE = 4'd8;
	localparam logic [3:0] ST_CL1 = 4'd9;
	localparam logic [3:0] ST_CL2 = 4'd10;
	localparam logic [3:0] ST_CL3 = 4'd11;
	localparam logic [3:0] ST_DONE = 4'd12;

	function automatic logic [28:0] sat_unit(input logic signed [39:0] v);
		logic [28:0] r;
		if (v < 0) r = '0;
		else if (v >= 40'sd268435456) r = 29'd268435456;
		else r = v[28:0];
		return r;
	endfunction

	function automatic logic [40:0] clamp_px(input logic [41:0] s, input logic [12:0] dim);
		logic [40:0] hi;
		logic [40:0] r;
		hi = {13'(dim - 13'd1), 28'd0};
		if (dim == 13'd0) r = '0;
		else if (s > {1'b0, hi}) r = hi;
		else r = s[40:0];
		return r;
	endfunction

	logic [3:0] state_q;
	logic axis_q;
	dbd_req_t req_q;
	logic [63:0] prod_q;
	logic signed [39:0] c_q;
	logic [19:0] u_q;
	logic [17:0] m_q;
	logic signed [39:0] lo_q;
	logic signed [39:0] hi_q;
	logic [40:0] a_q;
	logic [11:0] bx_q;
	logic [12:0] bw_q;
	logic [11:0] by_q;
	logic [12:0] bh_q;
	logic out_valid_q;
	logic [CLASS_W-1:0] cls_q;
	logic [15:0] conf_q;
	logic [11:0] box_x_q;
	logic [11:0] box_y_q;
	logic [12:0] box_w_q;
	logic [12:0] box_h_q;
	logic [PRIOR_W-1:0] prior_q;

	logic signed [15:0] d_c;
	logic signed [15:0] d_s;
	logic [15:0] ac;
	logic [15:0] as_v;
	logic [12:0] dim;
	logic [15:0] mag_c;
	logic [15:0] mag_s;
	logic [31:0] mul_a;
	logic [31:0] mul_b;
	logic [28:0] quot;
	logic signed [39:0] base;
	logic [31:0] tb;
	logic [3:0] ti;
	logic [17:0] tab_lo;
	logic [17:0] tab_hi;
	logic [48:0] ps;
	logic [35:0] half;
	logic [40:0] clamped;
	logic [41:0] len;
	logic load_out;

	assign d_c = axis_q ? req_q.dy : req_q.dx;
	assign d_s = axis_q ? req_q.dh : req_q.dw;
	assign ac = axis_q ? req_q.acy : req_q.acx;
	assign as_v = axis_q ? req_q.ah : req_q.aw;
	assign dim = axis_q ? image_height : image_width;
	assign mag_c = d_c[15] ? 16'(-d_c) : d_c;
	assign mag_s = d_s[15] ? 16'(-d_s) : d_s;
	assign quot = prod_q[63:35];
	assign base = 40'({ac, 12'd0});
	assign tb = d_s[15] ? 32'h8000_0000 - prod_q[31:0] : 32'h8000_0000 + prod_q[31:0];
	assign ti = u_q[15:12];
	assign tab_lo = POW2_TAB[ti];
	assign tab_hi = POW2_TAB[5'(ti) + 5'd1];
	assign ps = 49'(prod_q[33:0]) << u_q[19:16];
	assign half = ps[48:13];
	assign clamped = clamp_px(prod_q[41:0], dim);
	assign len = {1'b0, clamped} - {1'b0, a_q} + 42'd268435456;
	assign load_out = (state_q == ST_DONE) && (!out_valid_q || out_ready);

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_MUL1: begin
				mul_a = 32'(mag_c);
				mul_b = 32'(as_v);
			end
			ST_MUL2: begin
				mul_a = prod_q[31:0];
				mul_b = RECIP10;
			end
			ST_MUL3: begin
				mul_a = 32'(mag_s);
				mul_b = LOG2E_X_02;
			end
			ST_MUL5: begin
				mul_a = 32'(tab_hi - tab_lo);
				mul_b = 32'(u_q[11:0]);
			end
			ST_MUL7: begin
				mul_a = 32'(as_v);
				mul_b = 32'(m_q);
			end
			ST_CL1: begin
				mul_a = 32'(sat_unit(lo_q));
				mul_b = 32'(dim);
			end
			ST_CL2: begin
				mul_a = 32'(sat_unit(hi_q));
				mul_b = 32'(dim);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= 64'(mul_a) * 64'(mul_b);
		case (state_q)
			ST_IDLE: if (start) req_q <= req;
			ST_MUL3: c_q <= d_c[15] ? base - 40'(quot) : base + 40'(quot);
			ST_EXP: u_q <= tb[31:12];
			ST_MANT: m_q <= tab_lo + 18'(prod_q[24:12]);
			ST_SIZE: begin
				lo_q <= c_q - 40'(half);
				hi_q <= c_q + 40'(half);
			end
			ST_CL2: a_q <= clamped;
			ST_CL3: begin
				if (axis_q) begin
					by_q <= a_q[39:28];
					bh_q <= len[40:28];
				end else begin
					bx_q <= a_q[39:28];
					bw_q <= len[40:28];
				end
			end
			default: begin
			end
		endcase
		if (load_out) begin
			cls_q <= req_q.cls;
			conf_q <= req_q.score;
			prior_q <= req_q.prior;
			box_x_q <= bx_q;
			box_y_q <= by_q;
			box_w_q <= bw_q;
			box_h_q <= bh_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			axis_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_out) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					axis_q <= 1'b0;
					if (start) state_q <= ST_MUL1;
				end
				ST_MUL1: state_q <= ST_MUL2;
				ST_MUL2: state_q <= ST_MUL3;
				ST_MUL3: state_q <= ST_EXP;
				ST_EXP: state_q <= ST_MUL5;
				ST_MUL5: state_q <= ST_MANT;
				ST_MANT: state_q <= ST_MUL7;
				ST_MUL7: state_q <= ST_SIZE;
				ST_SIZE: state_q <= ST_CL1;
				ST_CL1: state_q <= ST_CL2;
				ST_CL2: state_q <= ST_CL3;
				ST_CL3: begin
					if (axis_q) state_q <= ST_DONE;
					else begin
						axis_q <= 1'b1;
						state_q <= ST_MUL1;
					end
				end
				ST_DONE: begin
					if (load_out) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign idle = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign class_id = cls_q;
	assign confidence = conf_q;
	assign box_x = box_x_q;
	assign box_y = box_y_q;
	assign box_w = box_w_q;
	assign box_h = box_h_q;
	assign prior_index = prior_q;
endmodule

/* hw/rtl/detection_box_decoder_unit.sv */
`timescale 1ns / 1ps
// channel | handshake                   | payload
// in      | in_valid / in_ready         | class_score, last_class, delta_*, anchor_*
// out     | out_valid / out_ready       | class_id, confidence, box_*, prior_index
// cfg     | cfg_valid / cfg_ready       | cfg_index, cfg_data
// Score words are taken back to back while the decoder is idle. A last word that passes the
// threshold starts the decoder, which runs both axes through one shared 32x32 multiplier
// and then loads the output register; in_ready is low throughout. A full output register holds
// the decoder in ST_DONE until out_ready. The output register holds a result while
// new words are taken. Reset clears the counters, the best score and out_valid.
module detection_box_decoder_unit #(
	parameter int NUM_CLASSES = dbd_pkg::NUM_CLASSES_DEF,
	parameter int MAX_PRIORS = dbd_pkg::MAX_PRIORS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic [15:0] class_score,
	input  logic last_class,
	input  logic signed [15:0] delta_x,
	input  logic signed [15:0] delta_y,
	input  logic signed [15:0] delta_w,
	input  logic signed [15:0] delta_h,
	input  logic [15:0] anchor_cx,
	input  logic [15:0] anchor_cy,
	input  logic [15:0] anchor_w,
	input  logic [15:0] anchor_h,
	output logic out_valid,
	input  logic out_ready,
	output logic [6:0] class_id,
	output logic [15:0] confidence,
	output logic [11:0] box_x,
	output logic [11:0] box_y,
	output logic [12:0] box_w,
	output logic [12:0] box_h,
	output logic [14:0] prior_index,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [15:0] cfg_data
);
	import dbd_pkg::*;

	logic [15:0] thr_q;
	logic [DIM_W-1:0] width_q;
	logic [DIM_W-1:0] height_q;
	logic [15:0] best_score_q;
	logic [CLASS_W-1:0] best_class_q;
	logic [CLASS_W-1:0] class_cnt_q;
	logic [PRIOR_W-1:0] prior_cnt_q;

	logic accept;
	logic take_new;
	logic [15:0] score_n;
	logic [CLASS_W-1:0] class_n;
	logic start;
	logic idle;
	dbd_req_t req;

	assign cfg_ready = 1'b1;
	assign in_ready = idle;
	assign accept = in_valid && in_ready;
	assign take_new = (class_cnt_q == '0) || (class_score > best_score_q);
	assign score_n = take_new ? class_score : best_score_q;
	assign class_n = take_new ? class_cnt_q : best_class_q;
	assign start = accept && last_class && (score_n > thr_q);

	assign req.dx = delta_x;
	assign req.dy = delta_y;
	assign req.dw = delta_w;
	assign req.dh = delta_h;
	assign req.acx = anchor_cx;
	assign req.acy = anchor_cy;
	assign req.aw = anchor_w;
	assign req.ah = anchor_h;
	assign req.cls = class_n;
	assign req.score = score_n;
	assign req.prior = prior_cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= 16'd32768;
			width_q <= 13'd640;
			height_q <= 13'd480;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_THRESHOLD: thr_q <= cfg_data;
				REG_WIDTH: width_q <= cfg_data[DIM_W-1:0];
				REG_HEIGHT: height_q <= cfg_data[DIM_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_score_q <= '0;
			best_class_q <= '0;
			class_cnt_q <= '0;
			prior_cnt_q <= '0;
		end else if (accept) begin
			if (last_class) begin
				best_score_q <= '0;
				best_class_q <= '0;
				class_cnt_q <= '0;
				if (prior_cnt_q >= PRIOR_W'(MAX_PRIORS - 1)) prior_cnt_q <= '0;
				else prior_cnt_q <= prior_cnt_q + 1'b1;
			end else begin
				best_score_q <= score_n;
				best_class_q <= class_n;
				if (class_cnt_q < CLASS_W'(NUM_CLASSES - 1)) class_cnt_q <= class_cnt_q + 1'b1;
			end
		end
	end

	dbd_decode u_decode (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.req(req),
		.image_width(width_q),
		.image_height(height_q),
		.idle(idle),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.class_id(class_id),
		.confidence(confidence),
		.box_x(box_x),
		.box_y(box_y),
		.box_w(box_w),
		.box_h(box_h),
		.prior_index(prior_index)
	);
endmodule
